[hw/rtl/mapt_pkg.sv]
// Shared constants for the link address translator: field widths, table sizing,
// configuration register indexes and beat layout constants.
// No dependencies.
package mapt_pkg;

   localparam int PREFIX_TABLE_DEPTH = 32;
   localparam int PREFIX_W = 24;
   localparam int ETH_W = 48;
   localparam int LONG_W = 64;
   localparam int SLOT_W = 5;
   localparam int IDX_W = (PREFIX_TABLE_DEPTH > 1) ? $clog2(PREFIX_TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(PREFIX_TABLE_DEPTH + 1);

   localparam int REQ_DATA_W = ETH_W + LONG_W;
   localparam int RSP_DATA_W = ETH_W + LONG_W;
   localparam int RSP_USER_W = 2;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_ETH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_LONG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SUBST_OWN = 2'd2;

   // Low three bits of byte 0 of a translated MAC: translate and local set,
   // multicast clear.
   localparam logic [2:0] TAG_TRANSLATED = 3'b110;
   localparam logic [15:0] EUI_FILL = 16'hFFFE;

endpackage

[hw/rtl/mapt_ram.sv]
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module mapt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mac_addr_prefix_translator.sv]
// Top level of the link address translator between 48-bit Ethernet MACs and
// 64-bit 802.15.4 long addresses, with a prefix table held in mapt_ram.
// Depends on mapt_pkg and mapt_ram.

// One request beat is translated at a time; req_tready is high only while the
// block is idle. A direct mapping (own address substitution, an FF,FE long
// address, or a plain MAC) goes from S_DECIDE straight to S_RESP. Restoring
// a prefix for a translated MAC passes through S_LOOKD first, since the prefix
// table is a RAM with a registered read. Translating a long address through
// the table scans the stored prefixes one entry per cycle on the single RAM
// read port, up to a hit or, for a new prefix, up to the fill count, where the
// prefix is inserted or refused on a full table. Responses sit in an output
// register, so the block can start the next beat while one is still waiting;
// it only stalls at its final step if the previous response has not been
// taken yet. The table needs no clearing after reset: entries are filled
// strictly in order, and an entry at or beyond the fill count reads as zero.
// The configuration port is always ready and is meant to be written while the
// block is idle.
module mac_addr_prefix_translator (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, low bit up: eth_addr[47:0], long_addr[63:0].
   input  logic [mapt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: mode (0 Ethernet to long, 1 long to Ethernet).
   input  logic                                req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, low bit up: eth_out[47:0], long_out[63:0].
   output logic [mapt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser, low bit up: ok, prefix_added.
   output logic [mapt_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mapt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mapt_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mapt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_LOOKD  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             chk_ff, chk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ETH_W-1:0] own_eth_ff, own_eth_in;
   logic [LONG_W-1:0] own_long_ff, own_long_in;
   logic             subst_ff, subst_in;

   // Payload.
   logic              mode_ff, mode_in;
   logic [ETH_W-1:0]  eth_ff, eth_in;
   logic [LONG_W-1:0] long_ff, long_in;
   logic [ETH_W-1:0]  res_eth_ff, res_eth_in;
   logic [LONG_W-1:0] res_long_ff, res_long_in;
   logic              res_ok_ff, res_ok_in;
   logic              res_add_ff, res_add_in;
   logic [ETH_W-1:0]  rsp_eth_ff, rsp_eth_in;
   logic [LONG_W-1:0] rsp_long_ff, rsp_long_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_add_ff, rsp_add_in;

   // Prefix table port.
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [PREFIX_W-1:0] ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [PREFIX_W-1:0] ram_rdata;

   logic                hit;
   logic [SLOT_W-1:0]   mac_slot;
   logic                slot_known;
   logic [PREFIX_W-1:0] pre;

   mapt_ram #(
      .WIDTH(PREFIX_W),
      .DEPTH(PREFIX_TABLE_DEPTH)
   ) u_prefix_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign pre = long_ff[LONG_W-1 -: PREFIX_W];
   // Table slot carried in the upper five bits of byte 0 of a translated MAC.
   assign mac_slot = eth_ff[ETH_W-1 -: SLOT_W];
   // Entries at or beyond the fill count were never written since reset.
   assign slot_known = (SLOT_W+1)'(mac_slot) < (SLOT_W+1)'(count_ff);
   // The read data belongs to the entry issued in the previous scan cycle.
   assign hit = chk_ff && (ram_rdata == pre);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      rsp_valid_in = rsp_valid_ff;
      own_eth_in   = own_eth_ff;
      own_long_in  = own_long_ff;
      subst_in     = subst_ff;
      mode_in      = mode_ff;
      eth_in       = eth_ff;
      long_in      = long_ff;
      res_eth_in   = res_eth_ff;
      res_long_in  = res_long_ff;
      res_ok_in    = res_ok_ff;
      res_add_in   = res_add_ff;
      rsp_eth_in   = rsp_eth_ff;
      rsp_long_in  = rsp_long_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_add_in   = rsp_add_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[IDX_W-1:0];
      ram_wdata    = pre;
      ram_raddr    = IDX_W'(mac_slot);

      if (csr_valid) begin
         unique case (csr_index)
            REG_OWN_ETH:   own_eth_in = csr_data[ETH_W-1:0];
            REG_OWN_LONG:  own_long_in = csr_data[LONG_W-1:0];
            REG_SUBST_OWN: subst_in = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               eth_in   = req_tdata[ETH_W-1:0];
               long_in  = req_tdata[REQ_DATA_W-1:ETH_W];
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_eth_in  = '0;
            res_long_in = '0;
            res_ok_in   = 1'b1;
            res_add_in  = 1'b0;
            if (mode_ff) begin
               if (subst_ff && (long_ff == own_long_ff)) begin
                  res_eth_in = own_eth_ff;
                  state_in   = S_RESP;
               end else if (long_ff[39:24] == EUI_FILL) begin
                  res_eth_in = {pre, long_ff[23:0]};
                  state_in   = S_RESP;
               end else begin
                  scan_in  = '0;
                  chk_in   = 1'b0;
                  state_in = S_SCAN;
               end
            end else begin
               if (subst_ff && (eth_ff == own_eth_ff)) begin
                  res_long_in = own_long_ff;
                  state_in    = S_RESP;
               end else if (eth_ff[42:40] == TAG_TRANSLATED) begin
                  // The table read for mac_slot is issued in this cycle.
                  state_in = S_LOOKD;
               end else begin
                  res_long_in = {eth_ff[47:24], EUI_FILL, eth_ff[23:0]};
                  state_in    = S_RESP;
               end
            end
         end
         S_SCAN: begin
            ram_raddr = scan_ff[IDX_W-1:0];
            if (hit) begin
               res_eth_in = {SLOT_W'(scan_ff - CNT_W'(1)), TAG_TRANSLATED, long_ff[39:0]};
               chk_in     = 1'b0;
               state_in   = S_RESP;
            end else if (scan_ff == count_ff) begin
               chk_in   = 1'b0;
               state_in = S_RESP;
               if (count_ff == CNT_W'(PREFIX_TABLE_DEPTH)) begin
                  // Table full: fall back to a direct copy.
                  res_eth_in = {pre, long_ff[23:0]};
                  res_ok_in  = 1'b0;
               end else begin
                  ram_we     = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
                  res_add_in = 1'b1;
                  res_eth_in = {SLOT_W'(count_ff), TAG_TRANSLATED, long_ff[39:0]};
               end
            end else begin
               scan_in = scan_ff + CNT_W'(1);
               chk_in  = 1'b1;
            end
         end
         S_LOOKD: begin
            res_long_in = {(slot_known ? ram_rdata : '0), eth_ff[39:0]};
            res_ok_in   = slot_known;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_eth_in   = res_eth_ff;
               rsp_long_in  = res_long_ff;
               rsp_ok_in    = res_ok_ff;
               rsp_add_in   = res_add_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_eth_ff   <= '0;
         own_long_ff  <= '0;
         subst_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         own_eth_ff   <= own_eth_in;
         own_long_ff  <= own_long_in;
         subst_ff     <= subst_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      eth_ff      <= eth_in;
      long_ff     <= long_in;
      res_eth_ff  <= res_eth_in;
      res_long_ff <= res_long_in;
      res_ok_ff   <= res_ok_in;
      res_add_ff  <= res_add_in;
      rsp_eth_ff  <= rsp_eth_in;
      rsp_long_ff <= rsp_long_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_add_ff  <= rsp_add_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_long_ff, rsp_eth_ff};
   assign rsp_tuser  = {rsp_add_ff, rsp_ok_ff};
   assign csr_ready  = 1'b1;

endmodule
